### rtl/core/psd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths, codes and transfer types of the point to segment distance
// pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

	localparam int CB     = 24;
	localparam int FB     = 8;
	localparam int DIST_W = 33;

	localparam int DW     = CB + 1;
	localparam int PW     = 2 * DW;
	localparam int SW     = PW + 1;
	localparam int LW     = 2 * DW;
	localparam int MW     = 2 * DW;
	localparam int HW     = MW / 2;
	localparam int CSQ_W  = 2 * MW;
	localparam int NUMW   = CSQ_W + 2 * FB;
	localparam int QW     = LW + 2 * FB;
	localparam int RW     = QW / 2;
	localparam int FRONT  = 6;
	localparam int NS     = FRONT + QW + RW;

	localparam logic [1:0] PART_START = 2'd0;
	localparam logic [1:0] PART_MID   = 2'd1;
	localparam logic [1:0] PART_END   = 2'd2;

	typedef struct packed {
		logic signed [CB-1:0] point_x;
		logic signed [CB-1:0] point_y;
		logic signed [CB-1:0] start_x;
		logic signed [CB-1:0] start_y;
		logic signed [CB-1:0] end_x;
		logic signed [CB-1:0] end_y;
	} query_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [1:0]        nearest_part;
	} result_t;

	typedef struct packed {
		logic [LW-1:0] rem;
		logic [QW-1:0] nq;
		logic [LW-1:0] dvs;
		logic [1:0]    part;
	} div_t;

	typedef struct packed {
		logic [QW-1:0]   rad;
		logic [RW+1:0]   rem;
		logic [RW-1:0]   root;
		logic [1:0]      part;
	} sqrt_t;

endpackage

### rtl/core/psd_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_div_step
// One registered stage of the restoring divider: one quotient bit per stage.
// ----------------------------------------------------------------------------
module psd_div_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  psd_pkg::div_t in_step,
	output logic          out_valid,
	output psd_pkg::div_t out_step
);

	logic [psd_pkg::LW:0]   r2;
	logic [psd_pkg::LW:0]   diff;
	logic                   ge;
	psd_pkg::div_t          nxt;

	always_comb begin
		r2   = {in_step.rem, in_step.nq[psd_pkg::QW-1]};
		diff = r2 - {1'b0, in_step.dvs};
		ge   = (r2 >= {1'b0, in_step.dvs});
		nxt.rem  = ge ? diff[psd_pkg::LW-1:0] : r2[psd_pkg::LW-1:0];
		nxt.nq   = {in_step.nq[psd_pkg::QW-2:0], ge};
		nxt.dvs  = in_step.dvs;
		nxt.part = in_step.part;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_step <= nxt;
		end
	end

endmodule

### rtl/core/psd_sqrt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_sqrt_step
// One registered stage of the integer square root: one root bit per stage.
// ----------------------------------------------------------------------------
module psd_sqrt_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  psd_pkg::sqrt_t in_step,
	output logic           out_valid,
	output psd_pkg::sqrt_t out_step
);

	logic [psd_pkg::RW+1:0] cand;
	logic [psd_pkg::RW+1:0] trial;
	logic [psd_pkg::RW+1:0] diff;
	logic                   ge;
	psd_pkg::sqrt_t         nxt;

	always_comb begin
		cand  = {in_step.rem[psd_pkg::RW-1:0], in_step.rad[psd_pkg::QW-1:psd_pkg::QW-2]};
		trial = {in_step.root, 2'b01};
		diff  = cand - trial;
		ge    = (cand >= trial);
		nxt.rem  = ge ? diff : cand;
		nxt.root = {in_step.root[psd_pkg::RW-2:0], ge};
		nxt.rad  = {in_step.rad[psd_pkg::QW-3:0], 2'b00};
		nxt.part = in_step.part;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_step <= nxt;
		end
	end

endmodule

### rtl/core/point_segment_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance
// Stages: six front stages, then one stage per quotient bit of the divider
// and one per root bit.
// Throughput: one transfer per cycle while no stall reaches the input; a
// stalled result holds only the run of full stages behind it; bubbles fill.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module point_segment_distance (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             query_valid,
	output logic             query_ready,
	input  psd_pkg::query_t  query,
	output logic             result_valid,
	input  logic             result_ready,
	output psd_pkg::result_t result
);

	localparam int DW    = psd_pkg::DW;
	localparam int PW    = psd_pkg::PW;
	localparam int SW    = psd_pkg::SW;
	localparam int LW    = psd_pkg::LW;
	localparam int MW    = psd_pkg::MW;
	localparam int HW    = psd_pkg::HW;
	localparam int CSQ_W = psd_pkg::CSQ_W;
	localparam int NUMW  = psd_pkg::NUMW;
	localparam int QW    = psd_pkg::QW;
	localparam int RW    = psd_pkg::RW;
	localparam int CB    = psd_pkg::CB;
	localparam int FB    = psd_pkg::FB;
	localparam int FRONT = psd_pkg::FRONT;
	localparam int NS    = psd_pkg::NS;

	logic [NS-1:0]    vld;
	logic [NS-1:0]    en;
	logic [FRONT-1:0] front_vld_q;

	assign vld[FRONT-1:0] = front_vld_q;

	for (genvar i = 0; i < NS; i++) begin : g_en
		assign en[i] = result_ready || !(&vld[NS-1:i]);
	end

	assign query_ready  = en[0];
	assign result_valid = vld[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_vld_q <= '0;
		end else begin
			if (en[0]) begin
				front_vld_q[0] <= query_valid;
			end
			for (int i = 1; i < FRONT; i++) begin
				if (en[i]) begin
					front_vld_q[i] <= front_vld_q[i-1];
				end
			end
		end
	end

	logic signed [DW-1:0] ex_s1, ey_s1, dx_s1, dy_s1, fx_s1, fy_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ex_s1 <= {query.end_x[CB-1], query.end_x} - {query.start_x[CB-1], query.start_x};
			ey_s1 <= {query.end_y[CB-1], query.end_y} - {query.start_y[CB-1], query.start_y};
			dx_s1 <= {query.point_x[CB-1], query.point_x} - {query.start_x[CB-1], query.start_x};
			dy_s1 <= {query.point_y[CB-1], query.point_y} - {query.start_y[CB-1], query.start_y};
			fx_s1 <= {query.point_x[CB-1], query.point_x} - {query.end_x[CB-1], query.end_x};
			fy_s1 <= {query.point_y[CB-1], query.point_y} - {query.end_y[CB-1], query.end_y};
		end
	end

	logic signed [PW-1:0] dxex_s2, dyey_s2, dxey_s2, dyex_s2;
	logic signed [PW-1:0] dxx_s2, dyy_s2, fxx_s2, fyy_s2, exx_s2, eyy_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dxex_s2 <= dx_s1 * ex_s1;
			dyey_s2 <= dy_s1 * ey_s1;
			dxey_s2 <= dx_s1 * ey_s1;
			dyex_s2 <= dy_s1 * ex_s1;
			dxx_s2  <= dx_s1 * dx_s1;
			dyy_s2  <= dy_s1 * dy_s1;
			fxx_s2  <= fx_s1 * fx_s1;
			fyy_s2  <= fy_s1 * fy_s1;
			exx_s2  <= ex_s1 * ex_s1;
			eyy_s2  <= ey_s1 * ey_s1;
		end
	end

	logic signed [SW-1:0] t_s3, cr_s3;
	logic [LW-1:0]        len_s3, da_s3, db_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			t_s3   <= dxex_s2 + dyey_s2;
			cr_s3  <= dxey_s2 - dyex_s2;
			len_s3 <= exx_s2 + eyy_s2;
			da_s3  <= dxx_s2 + dyy_s2;
			db_s3  <= fxx_s2 + fyy_s2;
		end
	end

	logic signed [SW-1:0] cr_neg;
	logic [MW-1:0]        mag;
	logic                 interior;
	logic [1:0]           part;
	logic [LW-1:0]        sel;

	always_comb begin
		cr_neg   = -cr_s3;
		mag      = cr_s3[SW-1] ? cr_neg[MW-1:0] : cr_s3[MW-1:0];
		interior = (len_s3 != '0) && !t_s3[SW-1] && (t_s3 != '0)
			&& (t_s3[SW-2:0] <= len_s3);
		if (interior) begin
			part = psd_pkg::PART_MID;
			sel  = da_s3;
		end else if ((len_s3 != '0) && (db_s3 < da_s3)) begin
			part = psd_pkg::PART_END;
			sel  = db_s3;
		end else begin
			part = psd_pkg::PART_START;
			sel  = da_s3;
		end
	end

	logic [1:0]    part_s4;
	logic [MW-1:0] mag_s4;
	logic [LW-1:0] sel_s4, len_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			part_s4 <= part;
			mag_s4  <= mag;
			sel_s4  <= sel;
			len_s4  <= len_s3;
		end
	end

	logic [2*HW-1:0] hh_s5, hl_s5, ll_s5;
	logic [1:0]      part_s5;
	logic [LW-1:0]   sel_s5, len_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			hh_s5   <= mag_s4[MW-1:HW] * mag_s4[MW-1:HW];
			hl_s5   <= mag_s4[MW-1:HW] * mag_s4[HW-1:0];
			ll_s5   <= mag_s4[HW-1:0] * mag_s4[HW-1:0];
			part_s5 <= part_s4;
			sel_s5  <= sel_s4;
			len_s5  <= len_s4;
		end
	end

	logic [CSQ_W-1:0] csq;
	logic [CSQ_W-1:0] num;
	logic [NUMW-1:0]  num_sh;
	psd_pkg::div_t    div_in;

	always_comb begin
		csq = (CSQ_W'(hh_s5) << MW) + (CSQ_W'(hl_s5) << (HW + 1)) + CSQ_W'(ll_s5);
		num = (part_s5 == psd_pkg::PART_MID) ? csq : CSQ_W'(sel_s5);
		num_sh = NUMW'(num) << (2 * FB);
		div_in.rem  = num_sh[NUMW-1:QW];
		div_in.nq   = num_sh[QW-1:0];
		div_in.dvs  = (part_s5 == psd_pkg::PART_MID) ? len_s5 : LW'(1);
		div_in.part = part_s5;
	end

	psd_pkg::div_t div_stage [0:QW];

	always_ff @(posedge clk) begin
		if (en[FRONT-1]) begin
			div_stage[0] <= div_in;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_div
		psd_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en[FRONT-1+k]),
			.in_valid  (vld[FRONT-2+k]),
			.in_step   (div_stage[k-1]),
			.out_valid (vld[FRONT-1+k]),
			.out_step  (div_stage[k])
		);
	end

	psd_pkg::sqrt_t sqrt_stage [0:RW];

	always_comb begin
		sqrt_stage[0].rad  = div_stage[QW].nq;
		sqrt_stage[0].rem  = '0;
		sqrt_stage[0].root = '0;
		sqrt_stage[0].part = div_stage[QW].part;
	end

	for (genvar j = 1; j <= RW; j++) begin : g_sqrt
		psd_sqrt_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en[FRONT-1+QW+j]),
			.in_valid  (vld[FRONT-2+QW+j]),
			.in_step   (sqrt_stage[j-1]),
			.out_valid (vld[FRONT-1+QW+j]),
			.out_step  (sqrt_stage[j])
		);
	end

	assign result.distance     = psd_pkg::DIST_W'(sqrt_stage[RW].root);
	assign result.nearest_part = sqrt_stage[RW].part;

endmodule
